### sv/bba_pkg.sv
// package with shared constants, codes and parameter defaults of the block allocator
`timescale 1ns / 1ps
package bba_pkg;

    localparam int MAP_BITS_DEF  = 8192;
    localparam int WORD_BITS_DEF = 64;

    // map index width: covers any 16 bit block number and a map of 65536 bits
    localparam int IDX_W   = 17;
    localparam int BLK_W   = 16;
    localparam int CNT_W   = 14;
    localparam int CFG_W   = 16;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    localparam logic [1:0] CMD_FORMAT  = 2'd0;
    localparam logic [1:0] CMD_RESERVE = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;
    localparam logic [1:0] CMD_QUERY   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_FREE     = 2'd3;

    localparam logic REG_DATA_START  = 1'b0;
    localparam logic REG_DATA_BLOCKS = 1'b1;

endpackage

### sv/bba_ram.sv
// generic single write port ram with one registered read port
`timescale 1ns / 1ps
module bba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/bba_find.sv
// lowest clear bit of one map word among the bits below the managed count
`timescale 1ns / 1ps
module bba_find #(
    parameter int WORD_BITS = bba_pkg::WORD_BITS_DEF,
    parameter int BW        = $clog2(WORD_BITS)
) (
    input  logic [WORD_BITS-1:0]      i_word,
    input  logic [bba_pkg::IDX_W-1:0] i_base,
    input  logic [bba_pkg::IDX_W-1:0] i_limit,
    output logic                      o_found,
    output logic [BW-1:0]             o_bit
);
    import bba_pkg::*;

    logic [IDX_W-1:0] w_avail;

    // bits of this word that lie below the managed count
    assign w_avail = (i_limit > i_base) ? (i_limit - i_base) : '0;

    always_comb begin
        o_found = 1'b0;
        o_bit   = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!i_word[b] && (IDX_W'(b) < w_avail)) begin
                o_found = 1'b1;
                o_bit   = BW'(b);
            end
        end
    end

endmodule

### sv/bitmap_block_allocator_core.sv
// top level of the bitmap block allocator: command sequencer around the usage map ram
// release and query read the addressed map word and then give their result, reserve with zero
// free count gives its result at once, reserve scans the map up to the first free bit (one map
// word read per cycle), format clears the map (one word cleared per cycle); one command at a time,
// so the next command is not accepted before the result has entered the output stage. after reset
// a clearing pass zeroes the map while no command is accepted; configuration writes are taken.
`timescale 1ns / 1ps
module bitmap_block_allocator_core #(
    parameter int MAP_BITS  = bba_pkg::MAP_BITS_DEF,
    parameter int WORD_BITS = bba_pkg::WORD_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_command,
    input  logic [bba_pkg::BLK_W-1:0] i_block_number,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [1:0]                o_status,
    output logic [bba_pkg::BLK_W-1:0] o_granted_block,
    output logic                      o_bit_value,
    output logic [bba_pkg::CNT_W-1:0] o_free_blocks,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [bba_pkg::CFG_W-1:0] i_cfg_data
);
    import bba_pkg::*;

    localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BW        = $clog2(WORD_BITS);
    localparam logic [AW-1:0]    LAST_WORD = AW'(MAP_WORDS - 1);
    localparam logic [AW-1:0]    SECOND    = AW'((MAP_WORDS > 1) ? 1 : 0);
    localparam logic [IDX_W-1:0] MAP_LIM   = IDX_W'(MAP_BITS);
    localparam logic [IDX_W-1:0] WB_I      = IDX_W'(WORD_BITS);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_REL   = 3'd3;
    localparam logic [2:0] S_QRY   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]       r_state;
    logic [AW-1:0]    r_word;
    logic [AW-1:0]    r_chk;
    logic [BW-1:0]    r_bit;
    logic             r_fmt;
    logic [CNT_W-1:0] r_free;
    logic [BLK_W-1:0] r_data_start;
    logic [CNT_W-1:0] r_data_blocks;
    logic [BLK_W-1:0] r_blk;
    logic [1:0]       r_res_status;
    logic [BLK_W-1:0] r_res_granted;
    logic             r_res_bit;
    logic             r_out_valid;
    logic [1:0]       r_out_status;
    logic [BLK_W-1:0] r_out_granted;
    logic             r_out_bit;
    logic [CNT_W-1:0] r_out_free;

    logic [IDX_W-1:0]     w_limit;
    logic [BLK_W-1:0]     w_idx;
    logic [AW-1:0]        w_iword;
    logic [BW-1:0]        w_ibit;
    logic                 w_accept;
    logic                 w_rel_bad;
    logic                 w_out_free;
    logic [IDX_W-1:0]     w_base;
    logic                 w_last;
    logic                 w_found;
    logic [BW-1:0]        w_fbit;
    logic [IDX_W-1:0]     w_grant_sum;
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [WORD_BITS-1:0] w_wdata;
    logic [AW-1:0]        w_raddr;
    logic [WORD_BITS-1:0] w_rdata;
    logic [WORD_BITS-1:0] w_onehot;

    assign w_limit = ({3'b000, r_data_blocks} > MAP_LIM) ? MAP_LIM
                                                         : {3'b000, r_data_blocks};
    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // release works on the offset block number, query on the map index itself
    assign w_idx   = (i_command == CMD_RELEASE) ? (i_block_number - r_data_start)
                                                : i_block_number;
    assign w_iword = AW'(w_idx / WORD_BITS);
    assign w_ibit  = BW'(w_idx % WORD_BITS);
    assign w_rel_bad = (i_block_number < r_data_start)
                    || ({1'b0, i_block_number - r_data_start} >= w_limit);

    assign w_base      = IDX_W'(r_chk) * WB_I;
    assign w_last      = ((w_base + WB_I) >= w_limit) || (r_chk == LAST_WORD);
    assign w_grant_sum = w_base + IDX_W'(w_fbit) + {1'b0, r_data_start};
    assign w_onehot    = (r_state == S_SCAN) ? (WORD_BITS'(1) << w_fbit)
                                             : (WORD_BITS'(1) << r_bit);

    bba_find #(
        .WORD_BITS(WORD_BITS),
        .BW       (BW)
    ) u_find (
        .i_word (w_rdata),
        .i_base (w_base),
        .i_limit(w_limit),
        .o_found(w_found),
        .o_bit  (w_fbit)
    );

    // read address comes straight from the command in idle so data is ready next cycle
    always_comb begin
        w_raddr = r_word;
        if (r_state == S_IDLE) begin
            if (i_command == CMD_RELEASE || i_command == CMD_QUERY) begin
                w_raddr = w_iword;
            end else begin
                w_raddr = '0;
            end
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_chk;
        w_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_word;
            end
            S_SCAN: begin
                w_we    = w_found;
                w_wdata = w_rdata | w_onehot;
            end
            S_REL: begin
                w_we    = w_rdata[r_bit];
                w_wdata = w_rdata & ~w_onehot;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    bba_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(MAP_WORDS),
        .AW   (AW)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_start  <= '0;
            r_data_blocks <= CNT_W'(8192);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_DATA_START:  r_data_start  <= i_cfg_data[BLK_W-1:0];
                REG_DATA_BLOCKS: r_data_blocks <= i_cfg_data[CNT_W-1:0];
                default: begin
                    r_data_start <= r_data_start;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_word      <= '0;
            r_fmt       <= 1'b0;
            r_free      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // in emit the output stage is refilled on the same edge instead
            if (r_out_valid && !i_out_stall && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (r_word == LAST_WORD) begin
                        r_word <= '0;
                        if (r_fmt) begin
                            r_fmt         <= 1'b0;
                            r_free        <= w_limit[CNT_W-1:0];
                            r_res_status  <= ST_OK;
                            r_res_granted <= '0;
                            r_res_bit     <= 1'b0;
                            r_state       <= S_EMIT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_word <= r_word + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_res_granted <= '0;
                        r_res_bit     <= 1'b0;
                        r_chk         <= (i_command == CMD_RESERVE) ? '0 : w_iword;
                        r_bit         <= w_ibit;
                        r_blk         <= i_block_number;
                        case (i_command)
                            CMD_FORMAT: begin
                                r_fmt   <= 1'b1;
                                r_word  <= '0;
                                r_state <= S_CLEAR;
                            end
                            CMD_RESERVE: begin
                                if (r_free == '0) begin
                                    r_res_status <= ST_NO_SPACE;
                                    r_state      <= S_EMIT;
                                end else begin
                                    r_word  <= SECOND;
                                    r_state <= S_SCAN;
                                end
                            end
                            CMD_RELEASE: begin
                                if (w_rel_bad) begin
                                    r_res_status <= ST_RANGE;
                                    r_state      <= S_EMIT;
                                end else begin
                                    r_state <= S_REL;
                                end
                            end
                            default: begin
                                if ({1'b0, i_block_number} >= MAP_LIM) begin
                                    r_res_status <= ST_RANGE;
                                    r_state      <= S_EMIT;
                                end else begin
                                    r_state <= S_QRY;
                                end
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // one word checked per cycle while the next one is being read
                    r_chk  <= r_word;
                    r_word <= (r_word == LAST_WORD) ? r_word : r_word + 1'b1;
                    if (w_found) begin
                        r_free        <= r_free - 1'b1;
                        r_res_status  <= ST_OK;
                        r_res_granted <= w_grant_sum[BLK_W-1:0];
                        r_state       <= S_EMIT;
                    end else if (w_last) begin
                        r_res_status <= ST_NO_SPACE;
                        r_state      <= S_EMIT;
                    end
                end
                S_REL: begin
                    r_res_granted <= r_blk;
                    if (w_rdata[r_bit]) begin
                        r_res_status <= ST_OK;
                        if (r_free != COUNT_MAX) begin
                            r_free <= r_free + 1'b1;
                        end
                    end else begin
                        r_res_status <= ST_FREE;
                    end
                    r_state <= S_EMIT;
                end
                S_QRY: begin
                    r_res_status <= ST_OK;
                    r_res_bit    <= w_rdata[r_bit];
                    r_state      <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output payload register, loaded on the transfer into the output stage
    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && w_out_free) begin
            r_out_status  <= r_res_status;
            r_out_granted <= r_res_granted;
            r_out_bit     <= r_res_bit;
            r_out_free    <= r_free;
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_granted_block = r_out_granted;
    assign o_bit_value     = r_out_bit;
    assign o_free_blocks   = r_out_free;

endmodule

### tb/bba_alloc_checker.sv
// checker for the block allocator: predicts each reply from the command stream and compares it
`timescale 1ns / 1ps
module bba_alloc_checker #(
    parameter int MAP_BITS = bba_pkg::MAP_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic [1:0]                i_command,
    input  logic [bba_pkg::BLK_W-1:0] i_block_number,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic [1:0]                i_status,
    input  logic [bba_pkg::BLK_W-1:0] i_granted_block,
    input  logic                      i_bit_value,
    input  logic [bba_pkg::CNT_W-1:0] i_free_blocks,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [bba_pkg::CFG_W-1:0] i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);
    import bba_pkg::*;

    typedef struct packed {
        logic [1:0]       status;
        logic [BLK_W-1:0] granted;
        logic             bitv;
        logic [CNT_W-1:0] blocks_free;
    } t_alloc_reply;

    bit               used_bits [0:MAP_BITS-1];
    logic [CNT_W-1:0] free_cnt;
    logic [BLK_W-1:0] cfg_start;
    logic [CNT_W-1:0] cfg_blocks;
    t_alloc_reply     alloc_replies_q [$];
    int               fails = 0;
    int               shown = 0;

    assign o_fail_count = fails;

    task automatic flag_mismatch(input string what);
        if (shown < 40) begin
            $display("[%0t] allocator mismatch: %s", $realtime, what);
            shown++;
        end
        fails++;
    endtask

    // updates the map copy and free count, returns the reply the block should give
    task automatic apply_alloc_cmd(input logic [1:0] cmd, input logic [BLK_W-1:0] blk,
                                   output t_alloc_reply r);
        int  limit;
        int  idx;
        int  k;
        int  sum;
        bit  found;
        limit = (int'(cfg_blocks) > MAP_BITS) ? MAP_BITS : int'(cfg_blocks);
        r = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_FORMAT: begin
                foreach (used_bits[j]) used_bits[j] = 1'b0;
                free_cnt = limit[CNT_W-1:0];
            end
            CMD_RESERVE: begin
                r.status = ST_NO_SPACE;
                found = 1'b0;
                if (free_cnt != '0) begin
                    for (k = 0; k < limit && !found; k++) begin
                        if (!used_bits[k]) begin
                            found = 1'b1;
                            used_bits[k] = 1'b1;
                            free_cnt = free_cnt - 1'b1;
                            sum = k + int'(cfg_start);
                            r.granted = sum[BLK_W-1:0];
                            r.status = ST_OK;
                        end
                    end
                end
            end
            CMD_RELEASE: begin
                if (int'(blk) < int'(cfg_start) || int'(blk) - int'(cfg_start) >= limit) begin
                    r.status = ST_RANGE;
                end else begin
                    idx = int'(blk) - int'(cfg_start);
                    r.granted = blk;
                    if (!used_bits[idx]) begin
                        r.status = ST_FREE;
                    end else begin
                        used_bits[idx] = 1'b0;
                        if (free_cnt != COUNT_MAX) free_cnt = free_cnt + 1'b1;
                    end
                end
            end
            default: begin
                if (int'(blk) >= MAP_BITS) r.status = ST_RANGE;
                else r.bitv = used_bits[blk];
            end
        endcase
        r.blocks_free = free_cnt;
    endtask

    always @(posedge i_clk) begin
        t_alloc_reply want;
        if (!i_rst_n) begin
            foreach (used_bits[j]) used_bits[j] = 1'b0;
            free_cnt = '0;
            cfg_start = '0;
            cfg_blocks = CNT_W'(8192);
            alloc_replies_q.delete();
        end else begin
            // the result leaving now always belongs to an older command
            if (i_out_valid && !i_out_stall) begin
                if (alloc_replies_q.size() == 0) begin
                    flag_mismatch($sformatf("result transfer with nothing pending, status %0d",
                                            i_status));
                end else begin
                    want = alloc_replies_q.pop_front();
                    if (i_status !== want.status)
                        flag_mismatch($sformatf("status %0d, want %0d", i_status, want.status));
                    if (i_granted_block !== want.granted)
                        flag_mismatch($sformatf("granted_block %0d, want %0d",
                                                i_granted_block, want.granted));
                    if (i_bit_value !== want.bitv)
                        flag_mismatch($sformatf("bit_value %0b, want %0b", i_bit_value, want.bitv));
                    if (i_free_blocks !== want.blocks_free)
                        flag_mismatch($sformatf("free_blocks %0d, want %0d",
                                                i_free_blocks, want.blocks_free));
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == REG_DATA_START) cfg_start = i_cfg_data[BLK_W-1:0];
                else cfg_blocks = i_cfg_data[CNT_W-1:0];
            end
            if (i_in_valid && !i_in_stall) begin
                apply_alloc_cmd(i_command, i_block_number, want);
                alloc_replies_q.push_back(want);
            end
        end
        o_pending <= alloc_replies_q.size();
    end

endmodule

### tb/tb_bitmap_block_allocator_core.sv
// testbench top for the bitmap block allocator: clock, reset, command stimulus and verdict
`timescale 1ns / 1ps
module tb_bitmap_block_allocator_core;
    import bba_pkg::*;

    localparam int MAP_WORDS   = MAP_BITS_DEF / WORD_BITS_DEF;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int PHASE_ITEMS = 410;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [1:0]       in_command = CMD_FORMAT;
    logic [BLK_W-1:0] in_block = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [1:0]       out_status;
    logic [BLK_W-1:0] out_granted;
    logic             out_bit;
    logic [CNT_W-1:0] out_free;
    logic             cfg_we = 1'b0;
    logic             cfg_index = REG_DATA_START;
    logic [CFG_W-1:0] cfg_data = '0;

    int fail_count;
    int pending;
    int idle_pct = 0;
    int stall_pct = 0;
    int cycle_cnt = 0;

    bitmap_block_allocator_core i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_command       (in_command),
        .i_block_number  (in_block),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_status        (out_status),
        .o_granted_block (out_granted),
        .o_bit_value     (out_bit),
        .o_free_blocks   (out_free),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    bba_alloc_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_command       (in_command),
        .i_block_number  (in_block),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_status        (out_status),
        .i_granted_block (out_granted),
        .i_bit_value     (out_bit),
        .i_free_blocks   (out_free),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("** bitmap_block_allocator_core: FAILED **");
            $finish;
        end
    end

    // one command transfer, with random idle cycles in front of it
    task automatic send_cmd(input logic [1:0] cmd, input logic [BLK_W-1:0] blk);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_command <= cmd;
        in_block   <= blk;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // holds off until every pending reply has been taken
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] start, input logic [CFG_W-1:0] blocks);
        cfg_we    <= 1'b1;
        cfg_index <= REG_DATA_START;
        cfg_data  <= start;
        @(posedge clk);
        cfg_index <= REG_DATA_BLOCKS;
        cfg_data  <= blocks;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // mostly reserve/release/query near the filled low end of the map, a few formats and
    // wild block numbers
    task automatic run_phase(input int s_idle, input int r_stall,
                             input logic [CFG_W-1:0] start, input logic [CFG_W-1:0] blocks);
        int               n_used;
        int               r;
        int               k;
        logic [BLK_W-1:0] blk;
        wait_idle();
        set_config(start, blocks);
        idle_pct  = s_idle;
        stall_pct = r_stall;
        n_used = 0;
        send_cmd(CMD_FORMAT, BLK_W'($urandom));
        for (k = 0; k < PHASE_ITEMS; k++) begin
            if (k == PHASE_ITEMS / 2) wait_idle();
            r   = $urandom_range(0, 99);
            blk = BLK_W'($urandom);
            if (r < 3) begin
                send_cmd(CMD_FORMAT, blk);
                n_used = 0;
            end else if (r < 45) begin
                send_cmd(CMD_RESERVE, blk);
                n_used++;
            end else if (r < 75) begin
                if ($urandom_range(0, 9) != 0)
                    blk = start[BLK_W-1:0] + BLK_W'($urandom_range(0, n_used + 1));
                send_cmd(CMD_RELEASE, blk);
            end else begin
                if ($urandom_range(0, 9) != 0) blk = BLK_W'($urandom_range(0, n_used + 3));
                send_cmd(CMD_QUERY, blk);
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset configuration: start 0, 8192 blocks, free count still zero
        send_cmd(CMD_QUERY, 16'd0);
        send_cmd(CMD_RESERVE, 16'd0);
        send_cmd(CMD_RELEASE, 16'd5);
        send_cmd(CMD_FORMAT, 16'hFFFF);
        send_cmd(CMD_RESERVE, 16'h0000);
        send_cmd(CMD_RESERVE, 16'hFFFF);
        send_cmd(CMD_RESERVE, 16'h1234);
        send_cmd(CMD_QUERY, 16'd1);
        send_cmd(CMD_QUERY, 16'd8191);
        send_cmd(CMD_QUERY, 16'd8192);
        send_cmd(CMD_QUERY, 16'hFFFF);
        send_cmd(CMD_RELEASE, 16'd1);
        send_cmd(CMD_RELEASE, 16'd1);
        send_cmd(CMD_RELEASE, 16'hFFFF);
        send_cmd(CMD_RESERVE, 16'd0);

        // shrink the managed range below the used bits: reserve finds nothing despite free count
        wait_idle();
        set_config(16'hFFFF, 16'd3);
        send_cmd(CMD_RESERVE, 16'd0);
        send_cmd(CMD_RELEASE, 16'hFFFF);
        send_cmd(CMD_RELEASE, 16'd0);
        send_cmd(CMD_RESERVE, 16'd0);

        // no managed blocks at all
        wait_idle();
        set_config(16'd100, 16'd0);
        send_cmd(CMD_FORMAT, 16'd0);
        send_cmd(CMD_RESERVE, 16'd0);
        send_cmd(CMD_RELEASE, 16'd100);

        // oversized block count is clipped to the map
        wait_idle();
        set_config(16'd0, 16'h3FFF);
        send_cmd(CMD_FORMAT, 16'd0);
        send_cmd(CMD_QUERY, 16'd0);

        run_phase(0, 0, 16'd0, 16'd8192);
        run_phase(88, 0, 16'd65235, CFG_W'($urandom_range(1, 200)));
        run_phase(0, 88, CFG_W'($urandom), 16'hFFFF);
        run_phase(19, 19, 16'd65505, 16'd65);

        wait_idle();
        repeat (MAP_WORDS + 20) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("** bitmap_block_allocator_core: PASSED **");
        end else begin
            $display("** bitmap_block_allocator_core: FAILED **");
        end
        $finish;
    end

endmodule
